// ===== rtl/core/grcc_pkg.sv =====
// grcc_pkg: shared constants for the grid ray column caster core
// map, texture and fixed point sizes, register indexes and port widths
// no dependencies
package grcc_pkg;

    // map, texture and walk limits
    localparam int MAP_SIZE  = 32;
    localparam int MAP_BITS  = $clog2(MAP_SIZE);
    localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int TEX_SIZE  = 64;
    localparam int TEX_BITS  = $clog2(TEX_SIZE);
    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int FRAC_BITS = 16;

    // port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int POS_W      = 21;
    localparam int VEC_W      = 18;
    localparam int SCR_W      = 12;
    localparam int COL_W      = 11;
    localparam int CODE_W     = 4;
    localparam int Q24_W      = 24;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X       = 3'd0,
        REG_CAMERA_Y       = 3'd1,
        REG_VIEW_DIR_X     = 3'd2,
        REG_VIEW_DIR_Y     = 3'd3,
        REG_VIEW_PLANE_X   = 3'd4,
        REG_VIEW_PLANE_Y   = 3'd5,
        REG_SCREEN_COLUMNS = 3'd6,
        REG_SCREEN_ROWS    = 3'd7
    } cfg_reg_t;

    // item commands
    localparam logic CMD_MAP_WRITE = 1'b0;
    localparam logic CMD_CAST      = 1'b1;

endpackage

// ===== rtl/core/grid_ray_column_caster_core.sv =====
// grid_ray_column_caster_core: map store plus DDA ray walk per screen column
// one shared restoring divider and one shared multiplier under a sequencer
// depends on grcc_pkg
//
// a map write beat leaves the sequencer idle; a cast beat runs it, and no new beat
// is taken until its result is loaded: divider passes for the camera coordinate and
// the x and y deltas, the step, lookup and check loop per grid step walked, then
// passes for line height and texture step; a zero ray component or a walk with no hit
// skips part of this; a full result register holds the sequencer until the result beat is taken
// reset restores the register defaults; map contents are undefined until written
module grid_ray_column_caster_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [grcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grcc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                cast_valid,
    output logic                                cast_ready,
    input  logic                                cmd,
    input  logic [grcc_pkg::COL_W-1:0]          column,
    input  logic [grcc_pkg::MAP_BITS-1:0]       cell_x,
    input  logic [grcc_pkg::MAP_BITS-1:0]       cell_y,
    input  logic [grcc_pkg::CODE_W-1:0]         cell_value,
    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [grcc_pkg::COL_W-1:0]          column_out,
    output logic                                wall_found,
    output logic                                hit_side,
    output logic [grcc_pkg::CODE_W-1:0]         wall_texture,
    output logic [grcc_pkg::Q24_W-1:0]          perp_distance,
    output logic [grcc_pkg::COL_W-1:0]          draw_start,
    output logic [grcc_pkg::COL_W-1:0]          draw_end,
    output logic [grcc_pkg::TEX_BITS-1:0]       tex_column,
    output logic [grcc_pkg::Q24_W-1:0]          tex_step,
    output logic [grcc_pkg::Q24_W-1:0]          tex_start
);
    import grcc_pkg::*;

    localparam int NUM_W  = 33;
    localparam int DEN_W  = 48;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int DIST_W = 48;
    localparam int DELTA_W = 39;
    localparam int RAY_W  = 32;
    localparam int CAM_W  = 30;
    localparam int LH_W   = 31;
    localparam int MA_W   = 34;
    localparam int MB_W   = 33;
    localparam int MP_W   = MA_W + MB_W;
    localparam int MPOS_W = MAP_BITS + 2;
    localparam int CAP_SH = 38 - FRAC_BITS;
    localparam logic [DELTA_W-1:0] DELTA_CAP = DELTA_W'(1) << 38;
    localparam logic [LH_W-1:0]    HEIGHT_CAP = LH_W'(1) << 30;
    localparam logic [Q24_W-1:0]   SAT24 = '1;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_CAM_END, S_MUL_RX, S_MUL_RY, S_DX_GO, S_DX_END,
        S_DY_GO, S_DY_END, S_SX_MUL, S_SY_MUL, S_SY_SET, S_STEP, S_LOOK,
        S_CHECK, S_PERP, S_LH_GO, S_LH_END, S_TX_GO, S_TX_END, S_WALL_MUL,
        S_POS_MUL, S_FIN, S_OUT
    } state_t;

    state_t state_reg, div_ret_reg;

    // configuration registers
    logic [POS_W-1:0]        camera_x_reg, camera_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [SCR_W-1:0]        columns_reg, rows_reg;

    // working registers
    logic [COL_W-1:0]        col_reg;
    logic signed [CAM_W-1:0] cam_reg;
    logic signed [RAY_W-1:0] rx_reg, ry_reg;
    logic [DELTA_W-1:0]      dx_reg, dy_reg;
    logic [DIST_W-1:0]       sx_reg, sy_reg, perp_reg;
    logic signed [MPOS_W-1:0] mx_reg, my_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    side_reg, hit_reg;
    logic [CODE_W-1:0]       code_reg;
    logic [LH_W-1:0]         lh_reg;
    logic [Q24_W-1:0]        txs_reg, tpos_reg;
    logic [TEX_BITS-1:0]     tx_reg;

    // divider registers
    logic [NUM_W-1:0]        div_num_reg, div_quo_reg;
    logic [DEN_W-1:0]        div_den_reg;
    logic [DEN_W:0]          div_rem_reg;
    logic [DCNT_W-1:0]       div_cnt_reg;

    // multiplier
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p_reg;
    logic signed [MP_W-1:0]  mul_sh;

    // map store
    logic [CODE_W-1:0]       map_mem [MAP_DEPTH];
    logic [CODE_W-1:0]       map_rd_reg;
    logic                    map_we;

    // output registers
    logic                    out_valid_reg;
    logic [COL_W-1:0]        out_col_reg, out_ds_reg, out_de_reg;
    logic                    out_hit_reg, out_side_reg;
    logic [CODE_W-1:0]       out_tex_reg;
    logic [Q24_W-1:0]        out_perp_reg, out_txs_reg, out_tpos_reg;
    logic [TEX_BITS-1:0]     out_tx_reg;

    // combinational helpers
    logic                    accept;
    logic [SCR_W-1:0]        w_eff, h_eff;
    logic [SCR_W-2:0]        half_h;
    logic [LH_W-2:0]         half_lh;
    logic [LH_W-1:0]         de_sum;
    logic [COL_W-1:0]        ds_c, de_c;
    logic [LH_W-2:0]         tpos_v;
    logic [DEN_W:0]          rem_sh, rem_sub;
    logic                    rem_ge;
    logic [LH_W-1:0]         abs_rx, abs_ry;
    logic [FRAC_BITS:0]      fx, fy;
    logic                    step_x;
    logic [FRAC_BITS-1:0]    wall;
    logic [TEX_BITS-1:0]     tx_raw;
    logic                    mirror;

    assign cast_ready = (state_reg == S_IDLE);
    assign accept     = cast_valid && cast_ready;
    assign map_we     = accept && (cmd == CMD_MAP_WRITE);

    // zero screen size acts as one
    assign w_eff  = (columns_reg == '0) ? SCR_W'(1) : columns_reg;
    assign h_eff  = (rows_reg == '0) ? SCR_W'(1) : rows_reg;
    assign half_h = h_eff[SCR_W-1:1];
    assign half_lh = lh_reg[LH_W-1:1];

    // draw span, clamped to the screen and to the output width
    always_comb
    begin
        ds_c = '0;
        if (LH_W'(half_h) > LH_W'(half_lh))
            ds_c = COL_W'(LH_W'(half_h) - LH_W'(half_lh));
        de_sum = LH_W'(half_lh) + LH_W'(half_h);
        if (de_sum >= LH_W'(h_eff))
            de_sum = LH_W'(h_eff) - LH_W'(1);
        de_c = (de_sum > LH_W'(2047)) ? COL_W'(2047) : de_sum[COL_W-1:0];
    end

    // texture row offset at draw start
    assign tpos_v = (half_lh > (LH_W-1)'(half_h)) ? half_lh - (LH_W-1)'(half_h) : '0;

    // divider step: shift in one numerator bit, subtract when it fits
    assign rem_sh  = {div_rem_reg[DEN_W-1:0], div_num_reg[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, div_den_reg};
    assign rem_sub = rem_sh - {1'b0, div_den_reg};

    // ray magnitudes and camera fractions toward the first grid line
    assign abs_rx = rx_reg[RAY_W-1] ? LH_W'(-rx_reg) : LH_W'(rx_reg);
    assign abs_ry = ry_reg[RAY_W-1] ? LH_W'(-ry_reg) : LH_W'(ry_reg);
    assign fx = rx_reg[RAY_W-1] ? {1'b0, camera_x_reg[FRAC_BITS-1:0]}
                                : (FRAC_BITS+1)'(1 << FRAC_BITS)
                                  - {1'b0, camera_x_reg[FRAC_BITS-1:0]};
    assign fy = ry_reg[RAY_W-1] ? {1'b0, camera_y_reg[FRAC_BITS-1:0]}
                                : (FRAC_BITS+1)'(1 << FRAC_BITS)
                                  - {1'b0, camera_y_reg[FRAC_BITS-1:0]};

    assign step_x = sx_reg < sy_reg;
    assign mul_sh = mul_p_reg >>> FRAC_BITS;

    // wall hit position and texture column
    assign wall = side_reg ? camera_x_reg[FRAC_BITS-1:0] + mul_p_reg[2*FRAC_BITS-1:FRAC_BITS]
                           : camera_y_reg[FRAC_BITS-1:0] + mul_p_reg[2*FRAC_BITS-1:FRAC_BITS];
    assign tx_raw = wall[FRAC_BITS-1:FRAC_BITS-TEX_BITS];
    assign mirror = (!side_reg && !rx_reg[RAY_W-1] && (rx_reg != '0))
                 || (side_reg && ry_reg[RAY_W-1]);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_RX:
            begin
                mul_a = MA_W'(plane_x_reg);
                mul_b = MB_W'(cam_reg);
            end
            S_MUL_RY:
            begin
                mul_a = MA_W'(plane_y_reg);
                mul_b = MB_W'(cam_reg);
            end
            S_SX_MUL:
            begin
                // a capped delta is a plain shift, handled at the load
                mul_a = $signed({1'b0, dx_reg[MA_W-2:0]});
                mul_b = $signed(MB_W'(fx));
            end
            S_SY_MUL:
            begin
                mul_a = $signed({1'b0, dy_reg[MA_W-2:0]});
                mul_b = $signed(MB_W'(fy));
            end
            S_WALL_MUL:
            begin
                mul_a = $signed(MA_W'(perp_reg[RAY_W-1:0]));
                mul_b = side_reg ? $signed({1'b0, rx_reg}) : $signed({1'b0, ry_reg});
            end
            S_POS_MUL:
            begin
                mul_a = $signed(MA_W'(tpos_v));
                mul_b = $signed(MB_W'(txs_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // map store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[{cell_y, cell_x}] <= cell_value;
        map_rd_reg <= map_mem[{my_reg[MAP_BITS-1:0], mx_reg[MAP_BITS-1:0]}];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg <= POS_W'(786432);
            camera_y_reg <= POS_W'(327680);
            dir_x_reg    <= -VEC_W'(65536);
            dir_y_reg    <= '0;
            plane_x_reg  <= '0;
            plane_y_reg  <= VEC_W'(43254);
            columns_reg  <= SCR_W'(800);
            rows_reg     <= SCR_W'(800);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAMERA_X:       camera_x_reg <= cfg_data[POS_W-1:0];
                REG_CAMERA_Y:       camera_y_reg <= cfg_data[POS_W-1:0];
                REG_VIEW_DIR_X:     dir_x_reg    <= $signed(cfg_data[VEC_W-1:0]);
                REG_VIEW_DIR_Y:     dir_y_reg    <= $signed(cfg_data[VEC_W-1:0]);
                REG_VIEW_PLANE_X:   plane_x_reg  <= $signed(cfg_data[VEC_W-1:0]);
                REG_VIEW_PLANE_Y:   plane_y_reg  <= $signed(cfg_data[VEC_W-1:0]);
                REG_SCREEN_COLUMNS: columns_reg  <= cfg_data[SCR_W-1:0];
                REG_SCREEN_ROWS:    rows_reg     <= cfg_data[SCR_W-1:0];
                default:            camera_x_reg <= camera_x_reg;
            endcase
        end
    end

    // sequencer, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_ret_reg   <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result beat taken; the load state handles its own cycle
            if (out_valid_reg && result_ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    // cast beat: start the camera coordinate division
                    if (accept && (cmd == CMD_CAST))
                    begin
                        col_reg     <= column;
                        hit_reg     <= 1'b0;
                        div_num_reg <= NUM_W'({column, (FRAC_BITS+1)'(0)});
                        div_den_reg <= DEN_W'(w_eff);
                        div_rem_reg <= '0;
                        div_cnt_reg <= DCNT_W'(NUM_W);
                        div_ret_reg <= S_CAM_END;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // one quotient bit per cycle
                    div_rem_reg <= rem_ge ? rem_sub : rem_sh;
                    div_num_reg <= {div_num_reg[NUM_W-2:0], 1'b0};
                    div_quo_reg <= {div_quo_reg[NUM_W-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(1))
                        state_reg <= div_ret_reg;
                end
                S_CAM_END:
                begin
                    cam_reg   <= $signed(CAM_W'(div_quo_reg)) - CAM_W'(1 << FRAC_BITS);
                    state_reg <= S_MUL_RX;
                end
                S_MUL_RX:
                    state_reg <= S_MUL_RY;
                S_MUL_RY:
                begin
                    rx_reg    <= RAY_W'(dir_x_reg) + mul_sh[RAY_W-1:0];
                    state_reg <= S_DX_GO;
                end
                S_DX_GO:
                begin
                    ry_reg <= RAY_W'(dir_y_reg) + mul_sh[RAY_W-1:0];
                    if (rx_reg == '0)
                    begin
                        dx_reg    <= DELTA_CAP;
                        state_reg <= S_DY_GO;
                    end
                    else
                    begin
                        div_num_reg <= NUM_W'(1) << (2*FRAC_BITS);
                        div_den_reg <= DEN_W'(abs_rx);
                        div_rem_reg <= '0;
                        div_cnt_reg <= DCNT_W'(NUM_W);
                        div_ret_reg <= S_DX_END;
                        state_reg   <= S_DIV;
                    end
                end
                S_DX_END:
                begin
                    dx_reg    <= DELTA_W'(div_quo_reg);
                    state_reg <= S_DY_GO;
                end
                S_DY_GO:
                begin
                    if (ry_reg == '0)
                    begin
                        dy_reg    <= DELTA_CAP;
                        state_reg <= S_SX_MUL;
                    end
                    else
                    begin
                        div_num_reg <= NUM_W'(1) << (2*FRAC_BITS);
                        div_den_reg <= DEN_W'(abs_ry);
                        div_rem_reg <= '0;
                        div_cnt_reg <= DCNT_W'(NUM_W);
                        div_ret_reg <= S_DY_END;
                        state_reg   <= S_DIV;
                    end
                end
                S_DY_END:
                begin
                    dy_reg    <= DELTA_W'(div_quo_reg);
                    state_reg <= S_SX_MUL;
                end
                S_SX_MUL:
                    state_reg <= S_SY_MUL;
                S_SY_MUL:
                begin
                    sx_reg    <= (dx_reg == DELTA_CAP) ? DIST_W'(fx) << CAP_SH
                                                       : DIST_W'(mul_p_reg[MP_W-1:FRAC_BITS]);
                    state_reg <= S_SY_SET;
                end
                S_SY_SET:
                begin
                    // starting cell of the walk
                    sy_reg    <= (dy_reg == DELTA_CAP) ? DIST_W'(fy) << CAP_SH
                                                       : DIST_W'(mul_p_reg[MP_W-1:FRAC_BITS]);
                    mx_reg    <= $signed(MPOS_W'(camera_x_reg[POS_W-1:FRAC_BITS]));
                    my_reg    <= $signed(MPOS_W'(camera_y_reg[POS_W-1:FRAC_BITS]));
                    step_reg  <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    // advance across the nearer grid line
                    if (step_x)
                    begin
                        sx_reg   <= sx_reg + DIST_W'(dx_reg);
                        mx_reg   <= rx_reg[RAY_W-1] ? mx_reg - MPOS_W'(1)
                                                    : mx_reg + MPOS_W'(1);
                        side_reg <= 1'b0;
                    end
                    else
                    begin
                        sy_reg   <= sy_reg + DIST_W'(dy_reg);
                        my_reg   <= ry_reg[RAY_W-1] ? my_reg - MPOS_W'(1)
                                                    : my_reg + MPOS_W'(1);
                        side_reg <= 1'b1;
                    end
                    step_reg  <= step_reg + STEP_W'(1);
                    state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    // leaving the map ends the walk with no hit
                    if (mx_reg < 0 || my_reg < 0
                        || mx_reg >= $signed(MPOS_W'(MAP_SIZE))
                        || my_reg >= $signed(MPOS_W'(MAP_SIZE)))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (map_rd_reg != '0)
                    begin
                        hit_reg   <= 1'b1;
                        code_reg  <= map_rd_reg;
                        state_reg <= S_PERP;
                    end
                    else if (step_reg == STEP_W'(MAX_STEPS))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_STEP;
                end
                S_PERP:
                begin
                    perp_reg  <= side_reg ? sy_reg - DIST_W'(dy_reg)
                                          : sx_reg - DIST_W'(dx_reg);
                    state_reg <= S_LH_GO;
                end
                S_LH_GO:
                begin
                    if (perp_reg == '0)
                    begin
                        lh_reg    <= HEIGHT_CAP;
                        state_reg <= S_TX_GO;
                    end
                    else
                    begin
                        div_num_reg <= NUM_W'({h_eff, FRAC_BITS'(0)});
                        div_den_reg <= perp_reg;
                        div_rem_reg <= '0;
                        div_cnt_reg <= DCNT_W'(NUM_W);
                        div_ret_reg <= S_LH_END;
                        state_reg   <= S_DIV;
                    end
                end
                S_LH_END:
                begin
                    lh_reg    <= LH_W'(div_quo_reg);
                    state_reg <= S_TX_GO;
                end
                S_TX_GO:
                begin
                    if (lh_reg == '0)
                    begin
                        txs_reg   <= SAT24;
                        state_reg <= S_WALL_MUL;
                    end
                    else
                    begin
                        div_num_reg <= NUM_W'(TEX_SIZE) << FRAC_BITS;
                        div_den_reg <= DEN_W'(lh_reg);
                        div_rem_reg <= '0;
                        div_cnt_reg <= DCNT_W'(NUM_W);
                        div_ret_reg <= S_TX_END;
                        state_reg   <= S_DIV;
                    end
                end
                S_TX_END:
                begin
                    txs_reg   <= (div_quo_reg > NUM_W'(SAT24)) ? SAT24
                                                               : div_quo_reg[Q24_W-1:0];
                    state_reg <= S_WALL_MUL;
                end
                S_WALL_MUL:
                    state_reg <= S_POS_MUL;
                S_POS_MUL:
                begin
                    tx_reg    <= mirror ? ~tx_raw : tx_raw;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    tpos_reg  <= (mul_p_reg[MP_W-1:Q24_W] != '0) ? SAT24
                                                                  : mul_p_reg[Q24_W-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // load the result beat once the result register is free
                    if (!out_valid_reg || result_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_col_reg   <= col_reg;
                        out_hit_reg   <= hit_reg;
                        out_side_reg  <= hit_reg & side_reg;
                        out_tex_reg   <= hit_reg ? code_reg - CODE_W'(1) : '0;
                        out_perp_reg  <= !hit_reg ? '0
                                       : (perp_reg > DIST_W'(SAT24)) ? SAT24
                                       : perp_reg[Q24_W-1:0];
                        out_ds_reg    <= hit_reg ? ds_c : '0;
                        out_de_reg    <= hit_reg ? de_c : '0;
                        out_tx_reg    <= hit_reg ? tx_reg : '0;
                        out_txs_reg   <= hit_reg ? txs_reg : '0;
                        out_tpos_reg  <= hit_reg ? tpos_reg : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // result port
    assign result_valid  = out_valid_reg;
    assign column_out    = out_col_reg;
    assign wall_found    = out_hit_reg;
    assign hit_side      = out_side_reg;
    assign wall_texture  = out_tex_reg;
    assign perp_distance = out_perp_reg;
    assign draw_start    = out_ds_reg;
    assign draw_end      = out_de_reg;
    assign tex_column    = out_tx_reg;
    assign tex_step      = out_txs_reg;
    assign tex_start     = out_tpos_reg;

endmodule

// ===== tb/grid_ray_column_caster_core_test.sv =====
// grid_ray_column_caster_core_test: self-checking bench for the ray column caster core
// fills the map, casts columns under several camera settings, checks every result
// depends on grcc_pkg and grid_ray_column_caster_core
module grid_ray_column_caster_core_test;
    import grcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic             cmd;
        logic [COL_W-1:0] column;
        logic [4:0]       cx;
        logic [4:0]       cy;
        logic [3:0]       code;
    } cast_beat_t;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic                found;
        logic                side;
        logic [3:0]          texture;
        logic [Q24_W-1:0]    perp;
        logic [COL_W-1:0]    dstart;
        logic [COL_W-1:0]    dend;
        logic [TEX_BITS-1:0] tcol;
        logic [Q24_W-1:0]    tstep;
        logic [Q24_W-1:0]    tstart;
    } column_hit_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic cast_valid;
    logic cast_ready;
    logic cmd;
    logic [COL_W-1:0] column;
    logic [MAP_BITS-1:0] cell_x;
    logic [MAP_BITS-1:0] cell_y;
    logic [CODE_W-1:0] cell_value;
    logic result_valid;
    logic result_ready;
    logic [COL_W-1:0] column_out;
    logic wall_found;
    logic hit_side;
    logic [CODE_W-1:0] wall_texture;
    logic [Q24_W-1:0] perp_distance;
    logic [COL_W-1:0] draw_start;
    logic [COL_W-1:0] draw_end;
    logic [TEX_BITS-1:0] tex_column;
    logic [Q24_W-1:0] tex_step;
    logic [Q24_W-1:0] tex_start;

    grid_ray_column_caster_core u_top (.*);

    // mirrored block state
    logic [3:0]         grid_copy [MAP_DEPTH];
    logic [20:0]        cam_x, cam_y;
    logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
    logic [11:0]        scr_cols, scr_rows;

    cast_beat_t  pending_beats[$];
    column_hit_t expected_hits[$];
    cast_beat_t  beat_on_bus;
    bit          beat_taken;
    int          send_idle, recv_idle;
    bit          hold_go;
    int          hold_left;
    int          errors;
    longint      cycles;

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // delta distance along one axis, saturated
    function automatic logic [63:0] axis_delta(input longint r);
        logic [63:0] a, d;
        a = (r < 0) ? 64'(-r) : 64'(r);
        if (a == 0)
            return 64'd1 << 38;
        d = (64'd1 << (2 * FRAC_BITS)) / a;
        return (d > (64'd1 << 38)) ? (64'd1 << 38) : d;
    endfunction

    function automatic logic [23:0] clip24(input logic [63:0] v);
        return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endfunction

    // DDA walk and wall slice for one column
    function automatic column_hit_t cast_column(input logic [COL_W-1:0] col);
        column_hit_t r;
        longint cam, rx, ry, mx, my, sgx, sgy, lh, ds, de;
        logic [63:0] w, h, dx, dy, sx, sy, fr, perp, q, txs, tpos, wpos, tx;
        bit side, hit;
        logic [3:0] code;
        r = '0;
        r.column = col;
        side = 0;
        hit = 0;
        code = 0;
        w = (scr_cols == 0) ? 64'd1 : 64'(scr_cols);
        h = (scr_rows == 0) ? 64'd1 : 64'(scr_rows);
        cam = longint'((64'(col) << (FRAC_BITS + 1)) / w) - ONE_Q;
        rx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> FRAC_BITS);
        ry = longint'(dir_y) + ((longint'(plane_y) * cam) >>> FRAC_BITS);
        dx = axis_delta(rx);
        dy = axis_delta(ry);
        mx = longint'(cam_x >> FRAC_BITS);
        my = longint'(cam_y >> FRAC_BITS);
        fr = 64'(cam_x) & 64'(ONE_Q - 1);
        sgx = (rx < 0) ? -1 : 1;
        sx = (((rx < 0) ? fr : 64'(ONE_Q) - fr) * dx) >> FRAC_BITS;
        fr = 64'(cam_y) & 64'(ONE_Q - 1);
        sgy = (ry < 0) ? -1 : 1;
        sy = (((ry < 0) ? fr : 64'(ONE_Q) - fr) * dy) >> FRAC_BITS;
        for (int n = 0; n < MAX_STEPS; n++)
        begin
            if (sx < sy)
            begin
                sx = sx + dx;
                mx = mx + sgx;
                side = 0;
            end
            else
            begin
                sy = sy + dy;
                my = my + sgy;
                side = 1;
            end
            if (mx < 0 || my < 0 || mx >= MAP_SIZE || my >= MAP_SIZE)
                break;
            code = grid_copy[my * MAP_SIZE + mx];
            if (code != 0)
            begin
                hit = 1;
                break;
            end
        end
        if (!hit)
            return r;
        perp = side ? sy - dy : sx - dx;
        if (perp == 0)
            lh = longint'(1) << 30;
        else
        begin
            q = (h << FRAC_BITS) / perp;
            lh = (q > (64'd1 << 30)) ? (longint'(1) << 30) : longint'(q);
        end
        ds = longint'(h / 2) - lh / 2;
        if (ds < 0)
            ds = 0;
        de = lh / 2 + longint'(h / 2);
        if (de >= longint'(h))
            de = longint'(h) - 1;
        txs = (lh != 0) ? (64'(TEX_SIZE) << FRAC_BITS) / 64'(lh) : '1;
        tpos = (lh != 0) ? 64'(ds - longint'(h / 2) + lh / 2) * txs : 64'd0;
        if (side == 0)
            wpos = 64'(cam_y) + ((perp * 64'(ry)) >> FRAC_BITS);
        else
            wpos = 64'(cam_x) + ((perp * 64'(rx)) >> FRAC_BITS);
        wpos = wpos & 64'(ONE_Q - 1);
        tx = (wpos * 64'(TEX_SIZE)) >> FRAC_BITS;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
            tx = 64'(TEX_SIZE) - tx - 1;
        r.found = 1'b1;
        r.side = side;
        r.texture = code - 4'd1;
        r.perp = clip24(perp);
        r.dstart = (ds > 2047) ? 11'd2047 : 11'(ds);
        r.dend = (de > 2047) ? 11'd2047 : 11'(de);
        r.tcol = tx[TEX_BITS-1:0];
        r.tstep = clip24(txs);
        r.tstart = clip24(tpos);
        return r;
    endfunction

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!cast_valid || beat_taken))
        begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                beat_on_bus <= pending_beats[0];
                cmd <= pending_beats[0].cmd;
                column <= pending_beats[0].column;
                cell_x <= pending_beats[0].cx;
                cell_y <= pending_beats[0].cy;
                cell_value <= pending_beats[0].code;
                cast_valid <= 1'b1;
                void'(pending_beats.pop_front());
            end
            else
                cast_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        result_ready <= rst_n && hold_left == 0 && $urandom_range(99) >= recv_idle;
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_go)
            hold_left <= 2000;
    end

    // accept input beats, check result beats, watch the cycle budget
    always @(posedge clk)
    begin
        column_hit_t exp_hit;
        column_hit_t got;
        beat_taken = cast_valid && cast_ready;
        if (beat_taken)
        begin
            if (beat_on_bus.cmd == CMD_MAP_WRITE)
                grid_copy[{beat_on_bus.cy, beat_on_bus.cx}] = beat_on_bus.code;
            else
                expected_hits.push_back(cast_column(beat_on_bus.column));
        end
        if (rst_n && result_valid && result_ready)
        begin
            got = '{column_out, wall_found, hit_side, wall_texture, perp_distance,
                    draw_start, draw_end, tex_column, tex_step, tex_start};
            if (expected_hits.size() == 0)
            begin
                $display("%t unexpected result beat: got %h", $realtime, got);
                errors++;
            end
            else
            begin
                exp_hit = expected_hits.pop_front();
                if (got !== exp_hit)
                begin
                    errors++;
                    $display("%t column %0d mismatch", $realtime, exp_hit.column);
                    if (got.column !== exp_hit.column)
                        $display("%t column_out exp %0d got %0d", $realtime,
                                 exp_hit.column, got.column);
                    if (got.found !== exp_hit.found)
                        $display("%t wall_found exp %0d got %0d", $realtime,
                                 exp_hit.found, got.found);
                    if (got.side !== exp_hit.side)
                        $display("%t hit_side exp %0d got %0d", $realtime,
                                 exp_hit.side, got.side);
                    if (got.texture !== exp_hit.texture)
                        $display("%t wall_texture exp %0d got %0d", $realtime,
                                 exp_hit.texture, got.texture);
                    if (got.perp !== exp_hit.perp)
                        $display("%t perp_distance exp %h got %h", $realtime,
                                 exp_hit.perp, got.perp);
                    if (got.dstart !== exp_hit.dstart)
                        $display("%t draw_start exp %0d got %0d", $realtime,
                                 exp_hit.dstart, got.dstart);
                    if (got.dend !== exp_hit.dend)
                        $display("%t draw_end exp %0d got %0d", $realtime,
                                 exp_hit.dend, got.dend);
                    if (got.tcol !== exp_hit.tcol)
                        $display("%t tex_column exp %0d got %0d", $realtime,
                                 exp_hit.tcol, got.tcol);
                    if (got.tstep !== exp_hit.tstep)
                        $display("%t tex_step exp %h got %h", $realtime,
                                 exp_hit.tstep, got.tstep);
                    if (got.tstart !== exp_hit.tstart)
                        $display("%t tex_start exp %h got %h", $realtime,
                                 exp_hit.tstart, got.tstart);
                end
            end
        end
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_map_write(input int x, input int y, input int v);
        cast_beat_t b;
        b = '{CMD_MAP_WRITE, 11'($urandom), 5'(x), 5'(y), 4'(v)};
        pending_beats.push_back(b);
    endtask

    task automatic add_cast(input int col);
        cast_beat_t b;
        b = '{CMD_CAST, 11'(col), 5'($urandom), 5'($urandom), 4'($urandom)};
        pending_beats.push_back(b);
    endtask

    // wait until every beat is in and every result is out
    task automatic drain();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || cast_valid || expected_hits.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [20:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_CAMERA_X:       cam_x = v;
            REG_CAMERA_Y:       cam_y = v;
            REG_VIEW_DIR_X:     dir_x = v[17:0];
            REG_VIEW_DIR_Y:     dir_y = v[17:0];
            REG_VIEW_PLANE_X:   plane_x = v[17:0];
            REG_VIEW_PLANE_Y:   plane_y = v[17:0];
            REG_SCREEN_COLUMNS: scr_cols = v[11:0];
            REG_SCREEN_ROWS:    scr_rows = v[11:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_view(input int p);
        if (p == 1)
        begin
            // everything at its top value
            write_reg(REG_CAMERA_X, 21'h1FFFFF);
            write_reg(REG_CAMERA_Y, 21'h1FFFFF);
            write_reg(REG_VIEW_DIR_X, 21'h1FFFF);
            write_reg(REG_VIEW_DIR_Y, 21'h1FFFF);
            write_reg(REG_VIEW_PLANE_X, 21'h1FFFF);
            write_reg(REG_VIEW_PLANE_Y, 21'h1FFFF);
            write_reg(REG_SCREEN_COLUMNS, 21'hFFF);
            write_reg(REG_SCREEN_ROWS, 21'hFFF);
        end
        else if (p == 2)
        begin
            // bottom values, zero screen sizes act as one
            write_reg(REG_CAMERA_X, 21'h0);
            write_reg(REG_CAMERA_Y, 21'h0);
            write_reg(REG_VIEW_DIR_X, 21'h20000);
            write_reg(REG_VIEW_DIR_Y, 21'h20000);
            write_reg(REG_VIEW_PLANE_X, 21'h20000);
            write_reg(REG_VIEW_PLANE_Y, 21'h20000);
            write_reg(REG_SCREEN_COLUMNS, 21'h0);
            write_reg(REG_SCREEN_ROWS, 21'h0);
        end
        else
        begin
            write_reg(REG_CAMERA_X, 21'($urandom_range(32'h1E0000, 32'h10000)));
            write_reg(REG_CAMERA_Y, 21'($urandom_range(32'h1E0000, 32'h10000)));
            write_reg(REG_VIEW_DIR_X, 21'($urandom));
            write_reg(REG_VIEW_DIR_Y, 21'($urandom));
            write_reg(REG_VIEW_PLANE_X, 21'($urandom_range(32'h1FFFF) - 32'h10000));
            write_reg(REG_VIEW_PLANE_Y, 21'($urandom));
            write_reg(REG_SCREEN_COLUMNS, 21'($urandom_range(2048, 1)));
            write_reg(REG_SCREEN_ROWS, 21'($urandom_range(2048, 1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cast_valid = 1'b0;
        cmd = CMD_MAP_WRITE;
        column = '0;
        cell_x = '0;
        cell_y = '0;
        cell_value = '0;
        result_ready = 1'b0;
        beat_on_bus = '0;
        beat_taken = 0;
        hold_go = 0;
        hold_left = 0;
        errors = 0;
        cycles = 0;
        send_idle = 15;
        recv_idle = 60;
        cam_x = 21'd786432;
        cam_y = 21'd327680;
        dir_x = -18'sd65536;
        dir_y = '0;
        plane_x = '0;
        plane_y = 18'sd43254;
        scr_cols = 12'd800;
        scr_rows = 12'd800;
        foreach (grid_copy[i])
            grid_copy[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every cell gets written before any cast: walled border, sparse inside
        for (int y = 0; y < MAP_SIZE; y++)
            for (int x = 0; x < MAP_SIZE; x++)
                if (x == 0 || y == 0 || x == MAP_SIZE - 1 || y == MAP_SIZE - 1)
                    add_map_write(x, y, $urandom_range(15, 1));
                else
                    add_map_write(x, y, ($urandom_range(99) < 25) ? $urandom_range(15, 1) : 0);

        // directed: screen edges, center column with zero y component
        add_cast(0);
        add_cast(799);
        add_cast(400);
        add_cast(2047);
        add_cast(1000);
        // camera sits on a grid line next to a wall: zero distance
        add_map_write(11, 5, 15);
        add_cast(400);
        add_map_write(11, 5, 0);
        add_cast(400);
        add_cast(0);
        add_cast(799);
        drain();

        // random phases under changing views
        for (int p = 0; p < 8; p++)
        begin
            if (p == 3)
            begin
                send_idle = 60;
                recv_idle = 15;
            end
            else if (p == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_view(p);
            for (int i = 0; i < 46; i++)
            begin
                if ($urandom_range(99) < 20)
                    add_map_write($urandom_range(31), $urandom_range(31),
                                  ($urandom_range(1)) ? 0 : $urandom_range(15, 1));
                else if ($urandom_range(99) < 85)
                    add_cast($urandom_range(((scr_cols == 0) ? 1 : scr_cols) - 1));
                else
                    add_cast($urandom_range(2047));
            end
            if (p == 4)
            begin
                // receiver holds off while casts keep coming
                @(negedge clk);
                hold_go = 1;
                @(posedge clk);
                @(posedge clk);
                hold_go = 0;
            end
            drain();
        end

        drain();
        repeat (400) @(posedge clk);
        if (errors == 0 && expected_hits.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
